// ----- design/tscs_pkg.sv -----
// ----------------------------------------------------------------------------
// tscs_pkg
// Shared types and constants of the triggered sample capture and statistics
// unit: command and register codes, the decoded operation and the result beat.
// ----------------------------------------------------------------------------
package tscs_pkg;

	localparam int BUFFER_DEPTH_DEF = 1024;
	localparam int QUEUE_DEPTH      = 4;
	localparam int LEVEL_W          = $clog2(QUEUE_DEPTH + 1);

	localparam int CMD_W    = 3;
	localparam int SAMPLE_W = 12;
	localparam int RIDX_W   = 10;
	localparam int COUNT_W  = 11;
	localparam int STAT_W   = 32;
	localparam int STATUS_W = 2;
	localparam int CFG_AW   = 2;
	localparam int CFG_DW   = 11;

	localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_IDLE       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CONFIGURED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RUNNING    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_COMPLETE   = 2'd3;

	localparam logic [CFG_AW-1:0] REG_TARGET     = 2'd0;
	localparam logic [CFG_AW-1:0] REG_CONTINUOUS = 2'd1;
	localparam logic [CFG_AW-1:0] REG_LOCKIN     = 2'd2;

	typedef enum logic [2:0] {
		OP_NOP    = 3'd0,
		OP_SAMPLE = 3'd1,
		OP_START  = 3'd2,
		OP_STOP   = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_READ   = 3'd5
	} op_kind_t;

	typedef struct packed {
		op_kind_t              kind;
		logic [SAMPLE_W-1:0]   sample;
		logic [RIDX_W-1:0]     entry_index;
	} op_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic                  not_ready;
		logic                  complete_event;
		logic [COUNT_W-1:0]    stored_count;
		logic [SAMPLE_W-1:0]   recent_sample;
		logic [SAMPLE_W-1:0]   lowest_sample;
		logic [SAMPLE_W-1:0]   highest_sample;
		logic [STAT_W-1:0]     sample_sum;
		logic [STAT_W-1:0]     samples_seen;
		logic [STAT_W-1:0]     lockin_sum;
		logic [STAT_W-1:0]     lockin_tally;
		logic [SAMPLE_W-1:0]   read_data;
	} result_t;

endpackage

// ----- design/tscs_ram.sv -----
// ----------------------------------------------------------------------------
// tscs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tscs_ram #(
	parameter int WIDTH  = 12,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/tscs_fifo.sv -----
// ----------------------------------------------------------------------------
// tscs_fifo
// Small register-based queue with a level output, used between the parts of
// the unit and in front of the result ports.
// ----------------------------------------------------------------------------
module tscs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic [CNT_W-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- design/tscs_front.sv -----
// ----------------------------------------------------------------------------
// tscs_front
// Accepts command beats, decodes the command code into an operation and
// queues it for the execution side.
// ----------------------------------------------------------------------------
module tscs_front import tscs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [RIDX_W-1:0]   entry_index,
	output logic                full,
	output logic                op_valid,
	output op_t                 op,
	input  logic                op_take
);

	op_t  dec;
	logic op_empty;

	always_comb begin
		dec.sample      = sample;
		dec.entry_index = entry_index;
		unique case (cmd)
			CMD_SAMPLE: dec.kind = OP_SAMPLE;
			CMD_START:  dec.kind = OP_START;
			CMD_STOP:   dec.kind = OP_STOP;
			CMD_CLEAR:  dec.kind = OP_CLEAR;
			CMD_READ:   dec.kind = OP_READ;
			default:    dec.kind = OP_NOP;
		endcase
	end

	tscs_fifo #(
		.WIDTH ($bits(op_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_op_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (dec),
		.full   (full),
		.pop    (op_take),
		.rdata  (op),
		.empty  (op_empty),
		.count  ()
	);

	assign op_valid = !op_empty;

endmodule

// ----- design/tscs_back.sv -----
// ----------------------------------------------------------------------------
// tscs_back
// Execution side: holds the capture state, statistics and sample buffer; forms
// the result beat; does one op per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module tscs_back import tscs_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_AW-1:0]  cfg_addr,
	input  logic [CFG_DW-1:0]  cfg_wdata,
	input  logic               op_valid,
	input  op_t                op,
	output logic               op_take,
	input  logic [LEVEL_W-1:0] out_level,
	output logic               res_valid,
	output result_t            res
);

	localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	logic [COUNT_W-1:0]  target_q, target_n;
	logic                cont_q, cont_n;
	logic                lk_en_q, lk_en_n;
	logic [STATUS_W-1:0] status_q, status_n;
	logic [COUNT_W-1:0]  wi_q, wi_n;
	logic [COUNT_W-1:0]  held_q, held_n;
	logic [SAMPLE_W-1:0] last_q, last_n;
	logic [SAMPLE_W-1:0] min_q, min_n;
	logic [SAMPLE_W-1:0] max_q, max_n;
	logic [STAT_W-1:0]   sum_q, sum_n;
	logic [STAT_W-1:0]   seen_q, seen_n;
	logic [STAT_W-1:0]   lk_sum_q, lk_sum_n;
	logic [STAT_W-1:0]   lk_cnt_q, lk_cnt_n;

	logic                nr, dn, rd_ok, wr_en;
	logic [COUNT_W-1:0]  wi_inc;
	logic                valid_s2, nr_s2, dn_s2, rd_ok_s2;
	logic [SAMPLE_W-1:0] rdata;

	// Leave room in the result queue for the beat already in the second stage.
	assign op_take = op_valid &&
		((32'(out_level) + 32'(valid_s2)) < 32'(QUEUE_DEPTH));
	assign wi_inc  = wi_q + COUNT_W'(1);

	always_comb begin
		target_n = target_q;
		cont_n   = cont_q;
		lk_en_n  = lk_en_q;
		status_n = status_q;
		wi_n     = wi_q;
		held_n   = held_q;
		last_n   = last_q;
		min_n    = min_q;
		max_n    = max_q;
		sum_n    = sum_q;
		seen_n   = seen_q;
		lk_sum_n = lk_sum_q;
		lk_cnt_n = lk_cnt_q;
		nr       = 1'b0;
		dn       = 1'b0;
		rd_ok    = 1'b0;
		wr_en    = 1'b0;
		if (op_take) begin
			unique case (op.kind)
				OP_SAMPLE: begin
					if (wi_q < target_q && 32'(wi_q) < 32'(BUFFER_DEPTH)) begin
						wr_en  = 1'b1;
						wi_n   = wi_inc;
						held_n = wi_inc;
					end
					seen_n = seen_q + STAT_W'(1);
					last_n = op.sample;
					// A minimum of zero means no sample has set it yet.
					if (op.sample < min_q || min_q == '0) begin
						min_n = op.sample;
					end
					if (op.sample > max_q) begin
						max_n = op.sample;
					end
					sum_n = sum_q + STAT_W'(op.sample);
					if (lk_en_q) begin
						lk_sum_n = lk_sum_q + STAT_W'(op.sample);
						lk_cnt_n = lk_cnt_q + STAT_W'(1);
					end
					if (wi_n >= target_q) begin
						if (!cont_q) begin
							status_n = ST_COMPLETE;
							dn       = 1'b1;
						end else begin
							wi_n = '0;
						end
					end
				end
				OP_START: begin
					if (status_q == ST_IDLE) begin
						nr = 1'b1;
					end else begin
						wi_n     = '0;
						held_n   = '0;
						status_n = ST_RUNNING;
					end
				end
				OP_STOP: status_n = ST_IDLE;
				OP_CLEAR: begin
					last_n = '0;
					min_n  = '0;
					max_n  = '0;
					sum_n  = '0;
					seen_n = '0;
				end
				OP_READ: begin
					rd_ok = (COUNT_W'(op.entry_index) < held_q) &&
						(32'(op.entry_index) < 32'(BUFFER_DEPTH));
				end
				default: ;
			endcase
		end
		if (cfg_we) begin
			unique case (cfg_addr)
				REG_TARGET: begin
					// A target beyond the buffer is dropped without effect.
					if (32'(cfg_wdata) <= 32'(BUFFER_DEPTH)) begin
						target_n = cfg_wdata;
						status_n = ST_CONFIGURED;
					end
				end
				REG_CONTINUOUS: begin
					cont_n   = cfg_wdata[0];
					status_n = ST_CONFIGURED;
				end
				REG_LOCKIN: begin
					lk_en_n = cfg_wdata[0];
					if (cfg_wdata[0]) begin
						lk_sum_n = '0;
						lk_cnt_n = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			cont_q   <= 1'b0;
			lk_en_q  <= 1'b0;
			status_q <= ST_IDLE;
			wi_q     <= '0;
			held_q   <= '0;
			last_q   <= '0;
			min_q    <= '0;
			max_q    <= '0;
			sum_q    <= '0;
			seen_q   <= '0;
			lk_sum_q <= '0;
			lk_cnt_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			target_q <= target_n;
			cont_q   <= cont_n;
			lk_en_q  <= lk_en_n;
			status_q <= status_n;
			wi_q     <= wi_n;
			held_q   <= held_n;
			last_q   <= last_n;
			min_q    <= min_n;
			max_q    <= max_n;
			sum_q    <= sum_n;
			seen_q   <= seen_n;
			lk_sum_q <= lk_sum_n;
			lk_cnt_q <= lk_cnt_n;
			valid_s2 <= op_take;
		end
	end

	always_ff @(posedge clk) begin
		nr_s2    <= nr;
		dn_s2    <= dn;
		rd_ok_s2 <= rd_ok;
	end

	tscs_ram #(
		.WIDTH  (SAMPLE_W),
		.DEPTH  (BUFFER_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ADDR_W'(32'(wi_q))),
		.wdata (op.sample),
		.raddr (ADDR_W'(32'(op.entry_index))),
		.rdata (rdata)
	);

	// In the second stage the state registers already hold the values left
	// by the operation, so the result is read straight from them.
	assign res_valid = valid_s2;

	always_comb begin
		res.status         = status_q;
		res.not_ready      = nr_s2;
		res.complete_event = dn_s2;
		res.stored_count   = held_q;
		res.recent_sample  = last_q;
		res.lowest_sample  = min_q;
		res.highest_sample = max_q;
		res.sample_sum     = sum_q;
		res.samples_seen   = seen_q;
		res.lockin_sum     = lk_sum_q;
		res.lockin_tally   = lk_cnt_q;
		res.read_data      = rd_ok_s2 ? rdata : '0;
	end

endmodule

// ----- design/triggered_sample_capture_stats_unit.sv -----
// ----------------------------------------------------------------------------
// triggered_sample_capture_stats_unit
// Captures triggered 12-bit samples into a buffer and keeps running statistics.
// ----------------------------------------------------------------------------
// Use: commands (sample, start, stop, statistics reset, buffer read) enter on
// the push/full side; a command beat is taken when push is high and full low.
// Every command gives exactly one result beat, which waits at the head of the
// result queue while empty is low and leaves when pop is high.
// Registers are written through cfg_we/cfg_addr/cfg_wdata; the user must write
// them only while no command is in flight, which the block does not enforce.
// A command passes through the command queue, the execute stage, the buffer
// read stage and the result queue. Throughput: one command per cycle while
// the result queue has room; the figure is set by the execute stage, which
// updates the index, the statistics and the sums together.
// When the receiver stalls, results collect in a four-deep queue, execution
// pauses, then the four-deep command queue fills and full rises; nothing is
// lost. Reset clears the queues, the state and the registers at once; the
// buffer contents are undefined until written and only entries below the
// stored count are ever returned.
// ----------------------------------------------------------------------------
module triggered_sample_capture_stats_unit import tscs_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_AW-1:0]   cfg_addr,
	input  logic [CFG_DW-1:0]   cfg_wdata,
	input  logic                push,
	output logic                full,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [RIDX_W-1:0]   entry_index,
	output logic                empty,
	input  logic                pop,
	output logic [STATUS_W-1:0] status,
	output logic                not_ready,
	output logic                complete_event,
	output logic [COUNT_W-1:0]  stored_count,
	output logic [SAMPLE_W-1:0] recent_sample,
	output logic [SAMPLE_W-1:0] lowest_sample,
	output logic [SAMPLE_W-1:0] highest_sample,
	output logic [STAT_W-1:0]   sample_sum,
	output logic [STAT_W-1:0]   samples_seen,
	output logic [STAT_W-1:0]   lockin_sum,
	output logic [STAT_W-1:0]   lockin_tally,
	output logic [SAMPLE_W-1:0] read_data
);

	logic               op_valid;
	op_t                op;
	logic               op_take;
	logic               res_valid;
	result_t            res;
	result_t            head;
	logic [LEVEL_W-1:0] out_level;

	tscs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.cmd         (cmd),
		.sample      (sample),
		.entry_index (entry_index),
		.full        (full),
		.op_valid    (op_valid),
		.op          (op),
		.op_take     (op_take)
	);

	tscs_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.op_valid  (op_valid),
		.op        (op),
		.op_take   (op_take),
		.out_level (out_level),
		.res_valid (res_valid),
		.res       (res)
	);

	tscs_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH),
		.CNT_W (LEVEL_W)
	) u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.wdata  (res),
		.full   (),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty),
		.count  (out_level)
	);

	assign status         = head.status;
	assign not_ready      = head.not_ready;
	assign complete_event = head.complete_event;
	assign stored_count   = head.stored_count;
	assign recent_sample  = head.recent_sample;
	assign lowest_sample  = head.lowest_sample;
	assign highest_sample = head.highest_sample;
	assign sample_sum     = head.sample_sum;
	assign samples_seen   = head.samples_seen;
	assign lockin_sum     = head.lockin_sum;
	assign lockin_tally   = head.lockin_tally;
	assign read_data      = head.read_data;

	// A refused start leaves the status idle.
	a_refused_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && not_ready) |-> (status == ST_IDLE))
		else $error("refused start reported with a status other than idle");

	// A completion beat always reports the complete status.
	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && complete_event) |-> (status == ST_COMPLETE))
		else $error("completion beat without complete status");

	// The execute stage never overruns the result queue.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_level == LEVEL_W'(QUEUE_DEPTH)) |-> !res_valid)
		else $error("result beat produced while the result queue was full");

	// The stored count never exceeds the buffer.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (32'(stored_count) <= 32'(BUFFER_DEPTH)))
		else $error("stored count beyond the buffer depth");

endmodule
